// File: hw/rtl/rmmn_pkg.sv
// Shared types, constants and helpers for the min/max normalize block.
// No dependencies; imported by every rmmn_* module and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rmmn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    // source range must exceed THRESH, 0.0001 in Q16.16 rounded down to 6 raw units
    localparam int THRESH = (1 << FRAC_BITS) / 10000;

    // divider: |target range| << FRAC_BITS over a 32-bit source range
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int DEN_W     = DATA_W;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    // (33-bit difference) * (32-bit scale), plus one bit for the offset add
    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = DIFF_W + DATA_W;
    localparam int SAT_W  = PROD_W + 1;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [DATA_W-1:0] MIN_RESET = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MAX_RESET = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] LOW_RESET = '0;
    localparam logic [DATA_W-1:0] HIGH_RESET = DATA_W'(1 << FRAC_BITS);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 1'b1;

    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_APPLY   = 1'b1;
    localparam logic KIND_STATS  = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    // queue entry between front and back
    typedef struct packed {
        logic              is_pixel;
        logic [DATA_W-1:0] red;
        logic [DATA_W-1:0] green;
        logic [DATA_W-1:0] blue;
        logic [DATA_W-1:0] alpha;
        logic [DATA_W-1:0] min_v;   // running min at the time of the item
        logic [DATA_W-1:0] max_v;   // stats entries only
    } rmmn_entry_t;

    typedef struct packed {
        logic              kind;
        logic              skipped;
        logic [DATA_W-1:0] red;
        logic [DATA_W-1:0] green;
        logic [DATA_W-1:0] blue;
        logic [DATA_W-1:0] alpha;
        logic [DATA_W-1:0] min_v;
        logic [DATA_W-1:0] max_v;
    } rmmn_result_t;

    // clamp a wide signed value into 32 signed bits
    function automatic logic [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic same;
        same = (&v[SAT_W-1:DATA_W-1]) | ~(|v[SAT_W-1:DATA_W-1]);
        if (same)
            return v[DATA_W-1:0];
        else if (v[SAT_W-1])
            return MAX_RESET;
        else
            return MIN_RESET;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rmmn_front.sv
// Front end: takes pixel transfers, folds measure pixels into the running
// min/max and queues stats and apply work. Depends on rmmn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmmn_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       action,
    input  wire logic [rmmn_pkg::DATA_W-1:0] red_in,
    input  wire logic [rmmn_pkg::DATA_W-1:0] green_in,
    input  wire logic [rmmn_pkg::DATA_W-1:0] blue_in,
    input  wire logic [rmmn_pkg::DATA_W-1:0] alpha_in,
    input  wire logic                       first_pixel,
    input  wire logic                       last_pixel,
    input  wire logic                       q_full,
    output logic                            q_push,
    output rmmn_pkg::rmmn_entry_t           q_entry
);
    import rmmn_pkg::*;

    logic [DATA_W-1:0] run_min_reg, run_min_next;
    logic [DATA_W-1:0] run_max_reg, run_max_next;
    logic [DATA_W-1:0] base_min, base_max;
    logic [DATA_W-1:0] lo_rg, hi_rg, lo_rgb, hi_rgb;
    logic              accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        base_min = first_pixel ? MIN_RESET : run_min_reg;
        base_max = first_pixel ? MAX_RESET : run_max_reg;

        lo_rg  = ($signed(red_in) < $signed(green_in)) ? red_in : green_in;
        hi_rg  = ($signed(red_in) > $signed(green_in)) ? red_in : green_in;
        lo_rgb = ($signed(blue_in) < $signed(lo_rg)) ? blue_in : lo_rg;
        hi_rgb = ($signed(blue_in) > $signed(hi_rg)) ? blue_in : hi_rg;

        run_min_next = run_min_reg;
        run_max_next = run_max_reg;
        if (accept && action == ACT_MEASURE) begin
            run_min_next = ($signed(lo_rgb) < $signed(base_min)) ? lo_rgb : base_min;
            run_max_next = ($signed(hi_rgb) > $signed(base_max)) ? hi_rgb : base_max;
        end

        q_push = accept && (action == ACT_APPLY || last_pixel);
        q_entry.is_pixel = (action == ACT_APPLY);
        if (action == ACT_APPLY) begin
            q_entry.red   = red_in;
            q_entry.green = green_in;
            q_entry.blue  = blue_in;
            q_entry.alpha = alpha_in;
            q_entry.min_v = run_min_reg;
            q_entry.max_v = '0;
        end else begin
            q_entry.red   = '0;
            q_entry.green = '0;
            q_entry.blue  = '0;
            q_entry.alpha = '0;
            q_entry.min_v = run_min_next;
            q_entry.max_v = run_max_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_min_reg <= MIN_RESET;
            run_max_reg <= MAX_RESET;
        end else begin
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rmmn_fifo.sv
// Short queue of work entries between front and back end.
// Depends on rmmn_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rmmn_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  rmmn_pkg::rmmn_entry_t      push_entry,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       head_valid,
    output rmmn_pkg::rmmn_entry_t      head_entry
);
    import rmmn_pkg::*;

    rmmn_entry_t     slot_reg [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]    count_reg, count_next;

    assign full       = (count_reg == (QAW+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rmmn_divider.sv
// Restoring divider, one quotient bit per cycle, for the scale factor.
// Unsigned magnitudes only; sign handled by the caller. Depends on rmmn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmmn_divider (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [rmmn_pkg::NUM_W-1:0]  dividend,
    input  wire logic [rmmn_pkg::DEN_W-1:0]  divisor,
    output logic                             done,
    output logic [rmmn_pkg::NUM_W-1:0]       quotient
);
    import rmmn_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [DEN_W:0]       trial;
    logic                 fits;

    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign fits     = (trial >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rmmn_back.sv
// Back end: works off queued entries one at a time, computes the scale,
// maps colour channels and holds the result register. Holds the target
// registers. Depends on rmmn_pkg and rmmn_divider.
`timescale 1ns / 1ps
`default_nettype none

module rmmn_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [rmmn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rmmn_pkg::DATA_W-1:0]   cfg_wdata,
    input  wire logic                          q_valid,
    input  rmmn_pkg::rmmn_entry_t              q_head,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output rmmn_pkg::rmmn_result_t             out_result
);
    import rmmn_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_MAP} state_t;

    state_t                    state_reg, state_next;
    logic [DATA_W-1:0]         tgt_low_reg, tgt_high_reg;
    logic signed [DATA_W-1:0]  scale_reg, scale_next;
    logic                      range_ok_reg, range_ok_next;
    logic                      neg_reg, neg_next;
    rmmn_entry_t               cur_reg, cur_next;
    logic [2:0]                cnt_reg, cnt_next;
    logic signed [DIFF_W-1:0]  d_reg, d_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [2:0][DATA_W-1:0]    res_reg, res_next;
    logic                      out_valid_reg, out_valid_next;
    rmmn_result_t              out_reg, out_next;

    logic                      div_start, div_done;
    logic [NUM_W-1:0]          div_quo;
    logic [NUM_W-1:0]          div_num;
    logic signed [DIFF_W-1:0]  src_w, tr_w, tr_mag;
    logic signed [SAT_W-1:0]   q_ext, mapped;
    logic [DATA_W-1:0]         chan;
    logic                      load;

    rmmn_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (src_w[DEN_W-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_comb begin
        src_w  = $signed({q_head.max_v[DATA_W-1], q_head.max_v})
               - $signed({q_head.min_v[DATA_W-1], q_head.min_v});
        tr_w   = $signed({tgt_high_reg[DATA_W-1], tgt_high_reg})
               - $signed({tgt_low_reg[DATA_W-1], tgt_low_reg});
        tr_mag = tr_w[DIFF_W-1] ? -tr_w : tr_w;
        div_num = {tr_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};

        q_ext = $signed(SAT_W'(div_quo));
        if (neg_reg)
            q_ext = -q_ext;

        mapped = SAT_W'(prod_reg >>> FRAC_BITS) + SAT_W'($signed(tgt_low_reg));

        unique case (cnt_reg[1:0])
            2'd0:    chan = cur_reg.red;
            2'd1:    chan = cur_reg.green;
            default: chan = cur_reg.blue;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        scale_next    = scale_reg;
        range_ok_next = range_ok_reg;
        neg_next      = neg_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        d_next        = d_reg;
        prod_next     = prod_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        q_pop         = 1'b0;
        div_start     = 1'b0;
        load          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && (!out_valid_reg || out_ready)) begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    if (!q_head.is_pixel) begin
                        range_ok_next = (src_w > $signed(DIFF_W'(THRESH)));
                        if (range_ok_next) begin
                            div_start  = 1'b1;
                            neg_next   = tr_w[DIFF_W-1];
                            state_next = ST_DIVIDE;
                        end else begin
                            scale_next       = '0;
                            load             = 1'b1;
                            out_next         = '0;
                            out_next.kind    = KIND_STATS;
                            out_next.skipped = 1'b1;
                            out_next.min_v   = q_head.min_v;
                            out_next.max_v   = q_head.max_v;
                        end
                    end else if (range_ok_reg) begin
                        cnt_next   = '0;
                        state_next = ST_MAP;
                    end else begin
                        // nothing to stretch against: pass the pixel through
                        load             = 1'b1;
                        out_next         = '0;
                        out_next.kind    = KIND_PIXEL;
                        out_next.skipped = 1'b1;
                        out_next.red     = q_head.red;
                        out_next.green   = q_head.green;
                        out_next.blue    = q_head.blue;
                        out_next.alpha   = q_head.alpha;
                    end
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    scale_next       = $signed(sat32(q_ext));
                    load             = 1'b1;
                    out_next         = '0;
                    out_next.kind    = KIND_STATS;
                    out_next.skipped = 1'b0;
                    out_next.min_v   = cur_reg.min_v;
                    out_next.max_v   = cur_reg.max_v;
                    state_next       = ST_IDLE;
                end
            end
            ST_MAP: begin
                // three-stage walk over R, G, B: subtract, multiply, shift/add/clamp
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg < 3'd3)
                    d_next = $signed({chan[DATA_W-1], chan})
                           - $signed({cur_reg.min_v[DATA_W-1], cur_reg.min_v});
                if (cnt_reg >= 3'd1 && cnt_reg <= 3'd3)
                    prod_next = d_reg * scale_reg;
                if (cnt_reg >= 3'd2 && cnt_reg <= 3'd4)
                    res_next[2'(cnt_reg - 3'd2)] = sat32(mapped);
                if (cnt_reg == 3'd5) begin
                    load             = 1'b1;
                    out_next         = '0;
                    out_next.kind    = KIND_PIXEL;
                    out_next.skipped = 1'b0;
                    out_next.red     = res_reg[0];
                    out_next.green   = res_reg[1];
                    out_next.blue    = res_reg[2];
                    out_next.alpha   = cur_reg.alpha;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        cnt_reg  <= cnt_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        neg_reg  <= neg_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scale_reg     <= '0;
            range_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tgt_low_reg   <= LOW_RESET;
            tgt_high_reg  <= HIGH_RESET;
        end else begin
            state_reg     <= state_next;
            scale_reg     <= scale_next;
            range_ok_reg  <= range_ok_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TARGET_LOW:  tgt_low_reg  <= cfg_wdata;
                    REG_TARGET_HIGH: tgt_high_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_map_needs_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MAP |-> range_ok_reg)
        else $error("channel mapping without a valid source range");

    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !out_valid_reg)
        else $error("result register occupied while an entry is in work");

    a_scale_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !range_ok_reg |-> scale_reg == '0)
        else $error("scale left nonzero with range flagged too small");

    a_div_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE && div_done) |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("divide finished without a stats transfer");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/rgb_min_max_normalize_top.sv
// Top level of the RGBA min/max contrast stretch: stream ports, front end,
// work queue and back end. Depends on rmmn_pkg, rmmn_front, rmmn_fifo, rmmn_back.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata r,g,b,a; tuser action,first; tlast
//  m_      | out | m_tvalid/m_tready  | tdata r,g,b,a,min,max; tuser kind,skipped
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata (target low / high)
//
// Measure pixels without last_pixel are taken one per cycle while the queue has
// room, and give no transfer. Stats entries whose range clears the threshold go
// through the one-bit-per-cycle divider; mapped pixels run the shared subtract,
// multiply and clamp stages over R, G, B; pass-through pixels go straight out.
// A 4-entry queue lets the front keep taking pixels while the back end works.
// aresetn is synchronous, active low; it restores targets and statistics.
`timescale 1ns / 1ps
`default_nettype none

module rgb_min_max_normalize_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [127:0]                  s_tdata,  // red, green, blue, alpha
    input  wire logic [1:0]                    s_tuser,  // action, first_pixel
    input  wire logic                          s_tlast,  // last_pixel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [191:0]                       m_tdata,  // red, green, blue, alpha, min, max
    output logic [1:0]                         m_tuser,  // kind, skipped
    input  wire logic                          cfg_we,
    input  wire logic [rmmn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rmmn_pkg::DATA_W-1:0]   cfg_wdata
);
    import rmmn_pkg::*;

    logic         q_full, q_push, q_pop, q_valid;
    rmmn_entry_t  q_entry, q_head;
    rmmn_result_t result;

    rmmn_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .action      (s_tuser[0]),
        .red_in      (s_tdata[31:0]),
        .green_in    (s_tdata[63:32]),
        .blue_in     (s_tdata[95:64]),
        .alpha_in    (s_tdata[127:96]),
        .first_pixel (s_tuser[1]),
        .last_pixel  (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    rmmn_fifo u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    rmmn_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {result.max_v, result.min_v, result.alpha,
                      result.blue, result.green, result.red};
    assign m_tuser = {result.skipped, result.kind};

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for rgb_min_max_normalize_top: drives measure/apply pixel
// streams and target writes, predicts every result in-bench. Needs rmmn_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import rmmn_pkg::*;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam int DRAIN_CYCLES = 64;   // room for the back end to finish a stats division

    typedef struct {
        logic        action;
        logic        first;
        logic        last;
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic [31:0] alpha;
    } pixel_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [127:0] s_tdata = '0;     // red, green, blue, alpha
    logic [1:0] s_tuser = '0;       // action, first_pixel
    logic s_tlast = 1'b0;           // last_pixel
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [191:0] m_tdata;          // red, green, blue, alpha, min, max
    logic [1:0] m_tuser;            // kind, skipped
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_wdata = '0;

    // bench copy of block state and targets
    longint tgt_low = 0;
    longint tgt_high = 64'sd1 << FRAC_BITS;
    longint stat_min = Q_MAX;
    longint stat_max = Q_MIN;
    longint gain = 0;
    bit gain_valid = 1'b0;

    rmmn_result_t stretch_expected[$];
    int mismatches = 0;
    int pixels_sent = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;

    rgb_min_max_normalize_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
    end

    function automatic longint clamp32(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    function automatic logic [31:0] stretch_channel(input logic [31:0] v);
        longint diff;
        longint prod;
        diff = longint'(signed'(v)) - stat_min;
        prod = diff * gain;
        return 32'(clamp32((prod >>> FRAC_BITS) + tgt_low));
    endfunction

    function automatic bit stretch_predict(input pixel_t p, output rmmn_result_t r);
        longint c [3];
        longint src;
        longint span;
        int i;
        r = '0;
        c[0] = longint'(signed'(p.red));
        c[1] = longint'(signed'(p.green));
        c[2] = longint'(signed'(p.blue));
        if (p.action == ACT_MEASURE) begin
            if (p.first) begin
                stat_min = Q_MAX;
                stat_max = Q_MIN;
            end
            for (i = 0; i < 3; i++) begin
                if (c[i] < stat_min)
                    stat_min = c[i];
                if (c[i] > stat_max)
                    stat_max = c[i];
            end
            if (!p.last)
                return 1'b0;
            src = stat_max - stat_min;
            span = tgt_high - tgt_low;
            gain_valid = src > THRESH;
            gain = gain_valid ? clamp32((span * (64'sd1 << FRAC_BITS)) / src) : 0;
            r.kind = KIND_STATS;
            r.min_v = stat_min[31:0];
            r.max_v = stat_max[31:0];
            r.skipped = !gain_valid;
            return 1'b1;
        end
        // marks are don't-care on apply pixels
        r.kind = KIND_PIXEL;
        r.alpha = p.alpha;
        r.skipped = !gain_valid;
        if (!gain_valid) begin
            r.red = p.red;
            r.green = p.green;
            r.blue = p.blue;
        end else begin
            r.red = stretch_channel(p.red);
            r.green = stretch_channel(p.green);
            r.blue = stretch_channel(p.blue);
        end
        return 1'b1;
    endfunction

    function automatic string fmt_result(input rmmn_result_t r);
        return $sformatf("kind=%0d skip=%0d rgba=%h %h %h %h min=%h max=%h",
                         r.kind, r.skipped, r.red, r.green, r.blue, r.alpha,
                         r.min_v, r.max_v);
    endfunction

    // result checker
    always @(posedge aclk) begin : check_results
        rmmn_result_t got;
        rmmn_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser[0];
            got.skipped = m_tuser[1];
            got.red = m_tdata[31:0];
            got.green = m_tdata[63:32];
            got.blue = m_tdata[95:64];
            got.alpha = m_tdata[127:96];
            got.min_v = m_tdata[159:128];
            got.max_v = m_tdata[191:160];
            if (stretch_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected transfer: %s", $time, fmt_result(got));
            end else begin
                want = stretch_expected.pop_front();
                if (got.kind !== want.kind || got.skipped !== want.skipped ||
                    got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha ||
                    got.min_v !== want.min_v || got.max_v !== want.max_v) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: mismatch expected: %s", $time, fmt_result(want));
                        $display("%0t: mismatch actual:   %s", $time, fmt_result(got));
                    end
                end
            end
        end
    end

    // one pixel transfer; tvalid stays high on return
    task automatic send_pixel(input logic action, first, last,
                              input logic [31:0] red, green, blue, alpha);
        pixel_t p;
        rmmn_result_t r;
        p = '{action, first, last, red, green, blue, alpha};
        // each cycle before the offer is idle with the given odds
        while (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {alpha, blue, green, red};
        s_tuser <= {first, action};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (stretch_predict(p, r))
            stretch_expected.push_back(r);
        pixels_sent++;
    endtask

    // drop tvalid, drain all results, let the back end go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (stretch_expected.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_targets(input logic [31:0] low, high);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= REG_TARGET_LOW;
        cfg_wdata <= low;
        @(posedge aclk);
        cfg_index <= REG_TARGET_HIGH;
        cfg_wdata <= high;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tgt_low = longint'(signed'(low));
        tgt_high = longint'(signed'(high));
    endtask

    function automatic logic [31:0] pick_chan(input logic [31:0] base, mask, input bit wide);
        logic [31:0] edges [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        if (wide && $urandom_range(0, 9) == 0)
            return $urandom;
        if (wide && $urandom_range(0, 9) == 0)
            return edges[$urandom_range(0, 3)];
        return base + ($urandom & mask);
    endfunction

    // measure pass then a run of apply pixels around the same level
    task automatic send_frame();
        int n;
        int napply;
        int i;
        bit wide;
        bit with_first;
        logic [31:0] base;
        logic [31:0] mask;
        n = $urandom_range(1, 6);
        napply = $urandom_range(1, 8);
        base = $urandom;
        mask = 32'hFFFF_FFFF >> $urandom_range(4, 30);
        wide = $urandom_range(0, 3) != 0;
        with_first = $urandom_range(0, 4) != 0;
        for (i = 0; i < n; i++)
            send_pixel(ACT_MEASURE, with_first && i == 0, i == n - 1,
                       pick_chan(base, mask, wide), pick_chan(base, mask, wide),
                       pick_chan(base, mask, wide), $urandom);
        for (i = 0; i < napply; i++)
            send_pixel(ACT_APPLY, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       pick_chan(base, {mask[30:0], 1'b1}, 1'b1),
                       pick_chan(base, {mask[30:0], 1'b1}, 1'b1),
                       pick_chan(base, {mask[30:0], 1'b1}, 1'b1), $urandom);
    endtask

    task automatic test_reset_passthrough();
        send_pixel(ACT_APPLY, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
        send_pixel(ACT_APPLY, 1'b0, 1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678,
                   32'h8000_0000);
    endtask

    task automatic test_basic_frame();
        set_targets(32'h0, 32'h0001_0000);
        send_pixel(ACT_MEASURE, 1'b1, 1'b0, 32'h0, 32'h0001_0000, 32'h0000_8000, 32'h0);
        send_pixel(ACT_MEASURE, 1'b0, 1'b0, 32'h0000_4000, 32'h0000_C000, 32'h0002_0000,
                   32'h7FFF_FFFF);
        send_pixel(ACT_MEASURE, 1'b0, 1'b1, 32'h0001_8000, 32'h0000_2000, 32'h0001_0000,
                   32'h0);
        send_pixel(ACT_APPLY, 1'b1, 1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h5A5A_A5A5);
        // red and green below the measured minimum, blue far above the maximum
        send_pixel(ACT_APPLY, 1'b0, 1'b0, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hA5A5_5A5A);
    endtask

    task automatic test_range_threshold();
        // range of exactly the threshold is still too small
        send_pixel(ACT_MEASURE, 1'b1, 1'b1, 32'h100, 32'h100 + THRESH, 32'h103, 32'h0);
        send_pixel(ACT_APPLY, 1'b0, 1'b0, 32'h100, 32'h200, 32'h300, 32'h1);
        send_pixel(ACT_MEASURE, 1'b1, 1'b1, 32'h100, 32'h100 + THRESH + 1, 32'h100, 32'h0);
        send_pixel(ACT_APPLY, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h103, 32'h2);
    endtask

    task automatic test_extreme_targets();
        set_targets(32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(ACT_MEASURE, 1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_pixel(ACT_APPLY, 1'b0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h3);
        // inverted target, tiny source range: scale clamps negative
        set_targets(32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(ACT_MEASURE, 1'b1, 1'b0, 32'h10, 32'h11, 32'h12, 32'h0);
        send_pixel(ACT_MEASURE, 1'b0, 1'b1, 32'h17, 32'h13, 32'h14, 32'h0);
        send_pixel(ACT_APPLY, 1'b0, 1'b0, 32'h10, 32'h17, 32'h0, 32'h4);
    endtask

    task automatic test_late_target_write();
        // latched scale stays, new target_low is the offset
        set_targets(32'h0001_0000, 32'h0);
        send_pixel(ACT_APPLY, 1'b0, 1'b0, 32'h10, 32'h12, 32'h17, 32'h5);
    endtask

    task automatic test_random_frames(input int gap, stall, input logic [31:0] low, high,
                                      input int n_items);
        int start;
        set_targets(low, high);
        tx_gap_pct = gap;
        rx_stall_pct = stall;
        start = pixels_sent;
        while (pixels_sent - start < n_items) begin
            if ($urandom_range(0, 11) == 0)
                set_targets($urandom, $urandom);
            if ($urandom_range(0, 99) < 15)
                send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)),
                           $urandom, $urandom, $urandom, $urandom);
            else
                send_frame();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_passthrough();
        test_basic_frame();
        test_range_threshold();
        test_extreme_targets();
        test_late_target_write();
        test_random_frames(0, 0, 32'h0, 32'h0001_0000, 150);
        test_random_frames(51, 0, $urandom, $urandom, 150);
        test_random_frames(0, 51, 32'h8000_0000, 32'h7FFF_FFFF, 150);
        test_random_frames(12, 12, 32'hFFFF_0000, 32'h0002_0000, 150);
        settle();
        if (mismatches == 0 && stretch_expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
